// File: rtl/nthrc_pkg.sv
// Shared types, register codes and fixed-point constants of the nozzle thermal step block.
package nthrc_pkg;

    localparam int unsigned CfgAddrW = 5;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned DivDw = 64;
    localparam int unsigned DivSw = 28;
    localparam int unsigned DivCntW = 5;

    localparam logic [31:0] ResetKelvin = 32'd312633754;
    localparam logic [32:0] CelsiusOffset = 33'd286418534;
    localparam logic signed [31:0] CelsiusMin = -32'sd286418534;
    localparam logic [23:0] UnitQ816 = 24'd65536;
    localparam logic [37:0] PowerLimit = '1;

    localparam logic [DivCntW-1:0] FlowLastStep = 5'd23;
    localparam logic [DivCntW-1:0] NodeLastStep = 5'd31;

    typedef enum logic [2:0] {
        CFG_BLOCK_CAP  = 3'd0,
        CFG_HEATER_CAP = 3'd1,
        CFG_SENSOR_CAP = 3'd2,
        CFG_AMBIENT_R  = 3'd3,
        CFG_HEATER_R   = 3'd4,
        CFG_SENSOR_R   = 3'd5,
        CFG_AMBIENT_K  = 3'd6,
        CFG_EXTRUDE_E  = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        NODE_HEATER = 2'd0,
        NODE_BLOCK  = 2'd1,
        NODE_SENSOR = 2'd2
    } t_node;

    typedef struct packed {
        logic               start;
        logic [DivCntW-1:0] last;
    } t_div_req;

endpackage

// File: rtl/nthrc_div.sv
// Shared restoring divider that resolves two quotient bits per cycle.
module nthrc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nthrc_pkg::t_div_req           i_req,
    input  logic [nthrc_pkg::DivDw-1:0]   i_dividend,
    input  logic [nthrc_pkg::DivSw-1:0]   i_divisor,
    output logic                          o_done,
    output logic [nthrc_pkg::DivDw-1:0]   o_quotient
);
    import nthrc_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DivCntW-1:0] r_cnt;
    logic [DivSw-1:0]   r_rem;
    logic [DivSw-1:0]   r_div;
    logic [DivDw-1:0]   r_dq;
    logic [DivSw-1:0]   n_rem;
    logic [DivDw-1:0]   n_dq;

    always_comb begin
        logic [DivSw:0]   t1;
        logic [DivSw:0]   t2;
        logic [DivSw-1:0] rem1;
        logic             b1;
        logic             b2;
        t1 = {r_rem, r_dq[DivDw-1]};
        b1 = t1 >= {1'b0, r_div};
        rem1 = b1 ? DivSw'(t1 - {1'b0, r_div}) : t1[DivSw-1:0];
        t2 = {rem1, r_dq[DivDw-2]};
        b2 = t2 >= {1'b0, r_div};
        n_rem = b2 ? DivSw'(t2 - {1'b0, r_div}) : t2[DivSw-1:0];
        n_dq = {r_dq[DivDw-3:0], b1, b2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.last;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_dq  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

// File: rtl/nozzle_thermal_rc_step.sv
// Top level of the three-node nozzle thermal step: registers, sequencer and shared datapath.
// Each accepted transfer advances the heater, block and sensor temperatures by one time step
// and returns the new sensor temperature in Celsius. The input is ready only while the block
// is idle, and a new item is not taken before the last one has reached the output register. Each
// of the three heat flows runs a divider start, divider steps at two quotient bits per cycle for
// the 48-bit dividend, and a done step. The extrusion product follows on the shared multiplier.
// Each of the three node updates then forms the net power, a product in a low and a high part
// on the shared 32x24 multiplier, a divider start, the divider steps and a done step. The
// Celsius conversion comes last and loads the output register. A result waiting in the output
// register does not hold off the next input, but that next item stalls in its last step until
// the output register is free. Configuration is written and read through the APB port at byte
// address 4*index and must only be written while no item is in flight.
module nozzle_thermal_rc_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [23:0]                        i_step_time,
    input  logic [23:0]                        i_heater_power,
    input  logic [23:0]                        i_extrusion_rate,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [31:0]                 o_sensor_celsius,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nthrc_pkg::CfgAddrW-1:0]     paddr,
    input  logic [nthrc_pkg::CfgDataW-1:0]     pwdata,
    output logic [nthrc_pkg::CfgDataW-1:0]     prdata,
    output logic                               pready
);
    import nthrc_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_FLOW_GO   = 10'b00_0000_0010,
        ST_FLOW_WAIT = 10'b00_0000_0100,
        ST_PX        = 10'b00_0000_1000,
        ST_NET       = 10'b00_0001_0000,
        ST_MUL_LO    = 10'b00_0010_0000,
        ST_MUL_HI    = 10'b00_0100_0000,
        ST_ADV_GO    = 10'b00_1000_0000,
        ST_ADV_WAIT  = 10'b01_0000_0000,
        ST_CELS      = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_node  r_idx, n_idx;

    logic [23:0] r_block_cap, r_heater_cap, r_sensor_cap;
    logic [23:0] r_amb_r, r_heater_r, r_sensor_r;
    logic [31:0] r_amb_k, r_ext_e;
    logic [31:0] r_temp_h, r_temp_b, r_temp_s;
    logic        r_out_valid;

    logic [23:0]        r_dt, r_pw, r_rate;
    logic signed [48:0] r_ph, r_pl, r_ps;
    logic [43:0]        r_px;
    logic               r_neg;
    logic [37:0]        r_pmag;
    logic [63:0]        r_acc;
    logic signed [31:0] r_celsius;

    logic        cfg_wr;
    t_cfg_reg    cfg_sel;
    logic        in_xfer;
    logic        out_load;

    logic [31:0]        fl_from, fl_to;
    logic [23:0]        fl_res;
    logic [32:0]        fl_diff;
    logic [31:0]        fl_mag;
    logic signed [48:0] fl_val;
    logic signed [51:0] net;
    logic [51:0]        net_mag;
    logic [37:0]        net_sat;
    logic [23:0]        cap_sel;
    logic [31:0]        temp_sel;
    logic [63:0]        adv_sum;
    logic [31:0]        temp_new;
    logic [32:0]        cels_diff;
    logic signed [31:0] cels_val;

    logic [31:0] mul_a;
    logic [23:0] mul_b;
    logic [55:0] mul_p;

    t_div_req          div_req;
    logic [DivDw-1:0]  div_dividend;
    logic [DivSw-1:0]  div_divisor;
    logic              div_done;
    logic [DivDw-1:0]  div_quot;

    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_sel  = t_cfg_reg'(paddr[CfgAddrW-1:2]);
    assign pready   = 1'b1;
    assign in_xfer  = i_in_valid & o_in_ready;
    assign out_load = (r_state == ST_CELS) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (cfg_sel)
            CFG_BLOCK_CAP:  prdata = {8'b0, r_block_cap};
            CFG_HEATER_CAP: prdata = {8'b0, r_heater_cap};
            CFG_SENSOR_CAP: prdata = {8'b0, r_sensor_cap};
            CFG_AMBIENT_R:  prdata = {8'b0, r_amb_r};
            CFG_HEATER_R:   prdata = {8'b0, r_heater_r};
            CFG_SENSOR_R:   prdata = {8'b0, r_sensor_r};
            CFG_AMBIENT_K:  prdata = r_amb_k;
            CFG_EXTRUDE_E:  prdata = r_ext_e;
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        case (r_idx)
            NODE_HEATER: begin
                fl_from  = r_temp_h;
                fl_to    = r_temp_b;
                fl_res   = r_heater_r;
                cap_sel  = r_heater_cap;
                temp_sel = r_temp_h;
                net      = $signed({24'b0, r_pw, 4'b0}) - 52'(r_ph);
            end
            NODE_BLOCK: begin
                fl_from  = r_temp_b;
                fl_to    = r_amb_k;
                fl_res   = r_amb_r;
                cap_sel  = r_block_cap;
                temp_sel = r_temp_b;
                net      = 52'(r_ph) - 52'(r_pl) - 52'(r_ps) - $signed({8'b0, r_px});
            end
            default: begin
                fl_from  = r_temp_b;
                fl_to    = r_temp_s;
                fl_res   = r_sensor_r;
                cap_sel  = r_sensor_cap;
                temp_sel = r_temp_s;
                net      = 52'(r_ps);
            end
        endcase
    end

    always_comb begin
        fl_diff = {1'b0, fl_from} - {1'b0, fl_to};
        fl_mag  = fl_diff[32] ? 32'(-fl_diff) : fl_diff[31:0];
        fl_val  = r_neg ? -$signed({1'b0, div_quot[47:0]}) : $signed({1'b0, div_quot[47:0]});

        net_mag = net[51] ? 52'(-net) : 52'(net);
        net_sat = (net_mag > {14'b0, PowerLimit}) ? PowerLimit : net_mag[37:0];

        adv_sum = {32'b0, temp_sel} + div_quot;
        if (!r_neg) begin
            temp_new = (adv_sum[63:32] != '0) ? '1 : adv_sum[31:0];
        end else if (div_quot > {32'b0, temp_sel}) begin
            temp_new = '0;
        end else begin
            temp_new = temp_sel - div_quot[31:0];
        end

        cels_diff = {1'b0, r_temp_s} - CelsiusOffset;
        cels_val  = (!cels_diff[32] && cels_diff[31]) ? 32'sh7FFF_FFFF
                                                      : $signed(cels_diff[31:0]);
    end

    always_comb begin
        case (r_state)
            ST_PX: begin
                mul_a = r_ext_e;
                mul_b = r_rate;
            end
            ST_MUL_HI: begin
                mul_a = {26'b0, r_pmag[37:32]};
                mul_b = r_dt;
            end
            default: begin
                mul_a = r_pmag[31:0];
                mul_b = r_dt;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        div_req.start = (r_state == ST_FLOW_GO) || (r_state == ST_ADV_GO);
        if (r_state == ST_FLOW_GO) begin
            div_req.last = FlowLastStep;
            div_dividend = {fl_mag, 32'b0};
            div_divisor  = {4'b0, (fl_res == '0) ? 24'd1 : fl_res};
        end else begin
            div_req.last = NodeLastStep;
            div_dividend = r_acc;
            div_divisor  = {(cap_sel == '0) ? 24'd1 : cap_sel, 4'b0};
        end
    end

    nthrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        t_node idx_inc;
        case (r_idx)
            NODE_HEATER: idx_inc = NODE_BLOCK;
            NODE_BLOCK:  idx_inc = NODE_SENSOR;
            default:     idx_inc = NODE_HEATER;
        endcase
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_FLOW_GO;
                    n_idx   = NODE_HEATER;
                end
            end
            ST_FLOW_GO: n_state = ST_FLOW_WAIT;
            ST_FLOW_WAIT: begin
                if (div_done) begin
                    n_idx   = idx_inc;
                    n_state = (r_idx == NODE_SENSOR) ? ST_PX : ST_FLOW_GO;
                end
            end
            ST_PX:     n_state = ST_NET;
            ST_NET:    n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ADV_GO;
            ST_ADV_GO: n_state = ST_ADV_WAIT;
            ST_ADV_WAIT: begin
                if (div_done) begin
                    n_idx   = idx_inc;
                    n_state = (r_idx == NODE_SENSOR) ? ST_CELS : ST_NET;
                end
            end
            ST_CELS: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= NODE_HEATER;
            r_out_valid  <= 1'b0;
            r_block_cap  <= UnitQ816;
            r_heater_cap <= UnitQ816;
            r_sensor_cap <= UnitQ816;
            r_amb_r      <= UnitQ816;
            r_heater_r   <= UnitQ816;
            r_sensor_r   <= UnitQ816;
            r_amb_k      <= ResetKelvin;
            r_ext_e      <= '0;
            r_temp_h     <= ResetKelvin;
            r_temp_b     <= ResetKelvin;
            r_temp_s     <= ResetKelvin;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end
            if (cfg_wr) begin
                case (cfg_sel)
                    CFG_BLOCK_CAP:  r_block_cap  <= pwdata[23:0];
                    CFG_HEATER_CAP: r_heater_cap <= pwdata[23:0];
                    CFG_SENSOR_CAP: r_sensor_cap <= pwdata[23:0];
                    CFG_AMBIENT_R:  r_amb_r      <= pwdata[23:0];
                    CFG_HEATER_R:   r_heater_r   <= pwdata[23:0];
                    CFG_SENSOR_R:   r_sensor_r   <= pwdata[23:0];
                    CFG_AMBIENT_K:  r_amb_k      <= pwdata;
                    CFG_EXTRUDE_E:  r_ext_e      <= pwdata;
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_ADV_WAIT) && div_done) begin
                case (r_idx)
                    NODE_HEATER: r_temp_h <= temp_new;
                    NODE_BLOCK:  r_temp_b <= temp_new;
                    default:     r_temp_s <= temp_new;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_dt   <= i_step_time;
                    r_pw   <= i_heater_power;
                    r_rate <= i_extrusion_rate;
                end
            end
            ST_FLOW_GO: r_neg <= fl_diff[32];
            ST_FLOW_WAIT: begin
                if (div_done) begin
                    case (r_idx)
                        NODE_HEATER: r_ph <= fl_val;
                        NODE_BLOCK:  r_pl <= fl_val;
                        default:     r_ps <= fl_val;
                    endcase
                end
            end
            ST_PX: r_px <= mul_p[55:12];
            ST_NET: begin
                r_neg  <= net[51];
                r_pmag <= net_sat;
            end
            ST_MUL_LO: r_acc <= {8'b0, mul_p};
            ST_MUL_HI: r_acc <= r_acc + {mul_p[31:0], 32'b0};
            ST_CELS: begin
                if (out_load) begin
                    r_celsius <= cels_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_sensor_celsius = r_celsius;

endmodule

// File: rtl/nthrc_chk.sv
// Port-level checker for the nozzle thermal step block and its bind to the top level.
module nthrc_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic signed [31:0]             o_sensor_celsius,
    input logic                           pready
);
    import nthrc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sensor_celsius))
        else $error("result changed or dropped before its transfer");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still ready right after a transfer");

    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready))
        else $error("result appeared one cycle after an input transfer");

    a_celsius_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sensor_celsius >= CelsiusMin)
        else $error("sensor temperature below absolute zero");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind nozzle_thermal_rc_step nthrc_chk u_nthrc_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_sensor_celsius (o_sensor_celsius),
    .pready           (pready)
);
